// ----- rtl/dcrg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcrg_pkg
// Shared types and codes for the deadlock-checked resource grant unit.
// ----------------------------------------------------------------------------
package dcrg_pkg;

	localparam int CFG_W = 5;   // width of the count registers
	localparam int CNT_W = 7;   // counts, cursors and positions up to 127

	localparam logic [1:0] ENTRY_NONE      = 2'd0;
	localparam logic [1:0] ENTRY_REQUESTED = 2'd1;
	localparam logic [1:0] ENTRY_HELD      = 2'd2;

	localparam logic [1:0] MODE_ACQUIRE = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_WRITE   = 2'd2;
	localparam logic [1:0] MODE_CHECK   = 2'd3;

	localparam logic REG_PROCESSES = 1'b0;
	localparam logic REG_RESOURCES = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PRE,
		ST_ROOT,
		ST_SCAN,
		ST_POP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] process_index;
		logic [3:0] resource_index;
		logic [1:0] entry_value;
	} cmd_t;

	typedef struct packed {
		logic deadlock_found;
		logic granted;
	} res_t;

endpackage
`default_nettype wire

// ----- rtl/deadlock_checked_resource_grant_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deadlock_checked_resource_grant_unit
// Process-by-resource claim table with a depth-first cycle search over the
// wait-for graph before each grant.
// ----------------------------------------------------------------------------
//  channel   signals                                direction
//  command   start, busy, cmd                       in  (beat on start & !busy)
//  result    result_valid, result                   out (one-cycle strobe)
//  config    psel penable pwrite paddr pwdata       in  (APB, pready tied high)
//            prdata
//
// After reset the claim memory is cleared one entry a cycle, with busy high.
// Release and write are done in the accepting cycle; the result shows the cycle after.
// An in-range acquire and every check first scan the table for waiting processes,
// then walk the graph from each unvisited root, examining table entries,
// following edges and dropping frames, and then finish.
// The single read port of the claim memory paces the scan and the walk.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module deadlock_checked_resource_grant_unit #(
	parameter int MAX_PROCESSES = 16,
	parameter int MAX_RESOURCES = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  dcrg_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              result_valid,
	output dcrg_pkg::res_t    result,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [2:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int NODES = MAX_PROCESSES + MAX_RESOURCES;
	localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(NODES);
	localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int DW    = $clog2(NODES + 1);
	localparam int CW    = dcrg_pkg::CNT_W;
	localparam int FW    = NW + CW;

	dcrg_pkg::state_t state_q, state_d;

	logic [dcrg_pkg::CFG_W-1:0] cfg_proc_q, cfg_res_q;
	dcrg_pkg::cmd_t             cmd_q;
	logic [AW-1:0]              clr_q;
	logic [CW-1:0]              pre_pi_q, pre_pj_q, root_q, scan_pos_q;
	logic [MAX_PROCESSES-1:0]   waiting_q;
	logic [NODES-1:0]           visited_q, on_path_q;
	logic [NW-1:0]              top_node_q;
	logic                       rd_valid_s1;
	logic [CW-1:0]              rd_pos_s1;
	logic [DW-1:0]              depth_q;
	logic                       found_q;
	logic                       result_valid_q;
	dcrg_pkg::res_t             result_q;

	logic [1:0]    claim_mem [DEPTH];
	logic [1:0]    claim_rd_q;
	logic [FW-1:0] stack_mem [NODES];
	logic [FW-1:0] stack_rd_q;

	logic          claim_we;
	logic [AW-1:0] claim_wa, claim_ra;
	logic [1:0]    claim_wd;
	logic          stack_we;
	logic [NW-1:0] stack_wa, stack_ra;
	logic [FW-1:0] stack_wd;

	logic [CW-1:0] np_c, nr_c, scan_limit, pos_inc;
	logic          accept, cmd_in_range, search_start;
	logic [AW-1:0] cmd_addr, cmd_q_addr, pre_addr, scan_addr;
	logic          pre_issue, pre_done;
	logic          top_is_proc, hit, scan_issue, exhausted, push;
	logic [NW-1:0] res_col, next_node;
	logic [DW-1:0] depth_m1, depth_m2;
	logic          cfg_wr;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		if (paddr[2] == dcrg_pkg::REG_RESOURCES) begin
			prdata = {{(32-dcrg_pkg::CFG_W){1'b0}}, cfg_res_q};
		end else begin
			prdata = {{(32-dcrg_pkg::CFG_W){1'b0}}, cfg_proc_q};
		end
	end

	// ---------------- derived values ----------------
	assign np_c = (CW'(cfg_proc_q) > CW'(MAX_PROCESSES)) ? CW'(MAX_PROCESSES) : CW'(cfg_proc_q);
	assign nr_c = (CW'(cfg_res_q) > CW'(MAX_RESOURCES)) ? CW'(MAX_RESOURCES) : CW'(cfg_res_q);

	assign busy   = (state_q != dcrg_pkg::ST_IDLE);
	assign accept = start && (state_q == dcrg_pkg::ST_IDLE);

	assign cmd_in_range = (CW'(cmd.process_index) < np_c) && (CW'(cmd.resource_index) < nr_c);
	assign search_start = ((cmd.mode == dcrg_pkg::MODE_ACQUIRE) && cmd_in_range)
		|| (cmd.mode == dcrg_pkg::MODE_CHECK);

	assign cmd_addr   = AW'(cmd.process_index) * AW'(MAX_RESOURCES) + AW'(cmd.resource_index);
	assign cmd_q_addr = AW'(cmd_q.process_index) * AW'(MAX_RESOURCES)
		+ AW'(cmd_q.resource_index);

	assign pre_issue = (pre_pi_q < np_c) && (pre_pj_q < nr_c);
	assign pre_done  = !pre_issue && !rd_valid_s1;
	assign pre_addr  = AW'(pre_pi_q) * AW'(MAX_RESOURCES) + AW'(pre_pj_q);

	assign top_is_proc = (top_node_q < NW'(MAX_PROCESSES));
	assign res_col     = top_node_q - NW'(MAX_PROCESSES);
	assign scan_limit  = top_is_proc ? nr_c : np_c;
	assign scan_addr   = top_is_proc
		? AW'(top_node_q) * AW'(MAX_RESOURCES) + AW'(scan_pos_q)
		: AW'(scan_pos_q) * AW'(MAX_RESOURCES) + AW'(res_col);

	// process rows follow requests, resource columns follow holders that wait
	assign hit = rd_valid_s1 && (top_is_proc
		? (claim_rd_q == dcrg_pkg::ENTRY_REQUESTED)
		: ((claim_rd_q == dcrg_pkg::ENTRY_HELD) && waiting_q[rd_pos_s1[PW-1:0]]));
	assign next_node  = top_is_proc ? NW'(MAX_PROCESSES) + NW'(rd_pos_s1) : NW'(rd_pos_s1);
	assign scan_issue = !hit && (scan_pos_q < scan_limit);
	assign exhausted  = !hit && !rd_valid_s1 && !(scan_pos_q < scan_limit);
	assign push       = hit && !on_path_q[next_node] && !visited_q[next_node];
	assign pos_inc    = rd_pos_s1 + 1'b1;
	assign depth_m1   = depth_q - 1'b1;
	assign depth_m2   = depth_q - DW'(2);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			dcrg_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = dcrg_pkg::ST_IDLE;
			end
			dcrg_pkg::ST_IDLE: begin
				if (accept && search_start) state_d = dcrg_pkg::ST_PRE;
			end
			dcrg_pkg::ST_PRE: begin
				if (pre_done) state_d = dcrg_pkg::ST_ROOT;
			end
			dcrg_pkg::ST_ROOT: begin
				if (!(root_q < np_c)) begin
					state_d = dcrg_pkg::ST_FINISH;
				end else if (!visited_q[root_q[NW-1:0]]) begin
					state_d = dcrg_pkg::ST_SCAN;
				end
			end
			dcrg_pkg::ST_SCAN: begin
				if (hit && on_path_q[next_node]) begin
					state_d = dcrg_pkg::ST_FINISH;
				end else if (exhausted) begin
					state_d = (depth_q == DW'(1)) ? dcrg_pkg::ST_ROOT : dcrg_pkg::ST_POP;
				end
			end
			dcrg_pkg::ST_POP:    state_d = dcrg_pkg::ST_SCAN;
			dcrg_pkg::ST_FINISH: state_d = dcrg_pkg::ST_IDLE;
			default:             state_d = dcrg_pkg::ST_IDLE;
		endcase
	end

	// ---------------- memory controls ----------------
	always_comb begin
		claim_we = 1'b0;
		claim_wa = cmd_addr;
		claim_wd = dcrg_pkg::ENTRY_NONE;
		claim_ra = scan_addr;
		stack_we = 1'b0;
		stack_wa = depth_m1[NW-1:0];
		stack_wd = {top_node_q, pos_inc};
		stack_ra = depth_m2[NW-1:0];
		case (state_q)
			dcrg_pkg::ST_CLEAR: begin
				claim_we = 1'b1;
				claim_wa = clr_q;
			end
			dcrg_pkg::ST_IDLE: begin
				if (accept && cmd_in_range) begin
					case (cmd.mode)
						dcrg_pkg::MODE_ACQUIRE: begin
							claim_we = 1'b1;
							claim_wd = dcrg_pkg::ENTRY_REQUESTED;
						end
						dcrg_pkg::MODE_RELEASE: claim_we = 1'b1;
						dcrg_pkg::MODE_WRITE: begin
							claim_we = (cmd.entry_value <= dcrg_pkg::ENTRY_HELD);
							claim_wd = cmd.entry_value;
						end
						default: claim_we = 1'b0;
					endcase
				end
			end
			dcrg_pkg::ST_PRE:  claim_ra = pre_addr;
			dcrg_pkg::ST_SCAN: stack_we = push;
			dcrg_pkg::ST_FINISH: begin
				claim_we = (cmd_q.mode == dcrg_pkg::MODE_ACQUIRE);
				claim_wa = cmd_q_addr;
				claim_wd = found_q ? dcrg_pkg::ENTRY_NONE : dcrg_pkg::ENTRY_HELD;
			end
			default: claim_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (claim_we) claim_mem[claim_wa] <= claim_wd;
		claim_rd_q <= claim_mem[claim_ra];
		if (stack_we) stack_mem[stack_wa] <= stack_wd;
		stack_rd_q <= stack_mem[stack_ra];
	end

	// ---------------- control and walk registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= dcrg_pkg::ST_CLEAR;
			cfg_proc_q     <= dcrg_pkg::CFG_W'(5);
			cfg_res_q      <= dcrg_pkg::CFG_W'(5);
			cmd_q          <= '0;
			clr_q          <= '0;
			pre_pi_q       <= '0;
			pre_pj_q       <= '0;
			root_q         <= '0;
			scan_pos_q     <= '0;
			waiting_q      <= '0;
			visited_q      <= '0;
			on_path_q      <= '0;
			top_node_q     <= '0;
			rd_valid_s1    <= 1'b0;
			rd_pos_s1      <= '0;
			depth_q        <= '0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2] == dcrg_pkg::REG_RESOURCES) begin
					cfg_res_q <= pwdata[dcrg_pkg::CFG_W-1:0];
				end else begin
					cfg_proc_q <= pwdata[dcrg_pkg::CFG_W-1:0];
				end
			end
			case (state_q)
				dcrg_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				dcrg_pkg::ST_IDLE: begin
					if (accept) begin
						cmd_q <= cmd;
						if (search_start) begin
							waiting_q   <= '0;
							visited_q   <= '0;
							on_path_q   <= '0;
							pre_pi_q    <= '0;
							pre_pj_q    <= '0;
							root_q      <= '0;
							rd_valid_s1 <= 1'b0;
							depth_q     <= '0;
							found_q     <= 1'b0;
						end else begin
							result_valid_q <= 1'b1;
							result_q       <= '0;
						end
					end
				end
				dcrg_pkg::ST_PRE: begin
					// stream the active rectangle, mark processes with a request open
					if (rd_valid_s1 && (claim_rd_q == dcrg_pkg::ENTRY_REQUESTED)) begin
						waiting_q[rd_pos_s1[PW-1:0]] <= 1'b1;
					end
					rd_valid_s1 <= pre_issue;
					if (pre_issue) begin
						rd_pos_s1 <= pre_pi_q;
						if (pre_pj_q + 1'b1 >= nr_c) begin
							pre_pj_q <= '0;
							pre_pi_q <= pre_pi_q + 1'b1;
						end else begin
							pre_pj_q <= pre_pj_q + 1'b1;
						end
					end
				end
				dcrg_pkg::ST_ROOT: begin
					if (root_q < np_c) begin
						if (visited_q[root_q[NW-1:0]]) begin
							root_q <= root_q + 1'b1;
						end else begin
							visited_q[root_q[NW-1:0]] <= 1'b1;
							on_path_q[root_q[NW-1:0]] <= 1'b1;
							top_node_q  <= root_q[NW-1:0];
							scan_pos_q  <= '0;
							rd_valid_s1 <= 1'b0;
							depth_q     <= DW'(1);
						end
					end
				end
				dcrg_pkg::ST_SCAN: begin
					if (hit) begin
						rd_valid_s1 <= 1'b0;
						if (on_path_q[next_node]) begin
							found_q <= 1'b1;
						end else if (push) begin
							visited_q[next_node] <= 1'b1;
							on_path_q[next_node] <= 1'b1;
							top_node_q <= next_node;
							scan_pos_q <= '0;
							depth_q    <= depth_q + 1'b1;
						end else begin
							scan_pos_q <= pos_inc;
						end
					end else if (scan_issue) begin
						rd_valid_s1 <= 1'b1;
						rd_pos_s1   <= scan_pos_q;
						scan_pos_q  <= scan_pos_q + 1'b1;
					end else if (rd_valid_s1) begin
						rd_valid_s1 <= 1'b0;
					end else begin
						// no edge left: drop the frame
						on_path_q[top_node_q] <= 1'b0;
						depth_q <= depth_m1;
					end
				end
				dcrg_pkg::ST_POP: begin
					top_node_q  <= stack_rd_q[FW-1:CW];
					scan_pos_q  <= stack_rd_q[CW-1:0];
					rd_valid_s1 <= 1'b0;
				end
				dcrg_pkg::ST_FINISH: begin
					result_valid_q          <= 1'b1;
					result_q.deadlock_found <= found_q;
					result_q.granted        <= (cmd_q.mode == dcrg_pkg::MODE_ACQUIRE) && !found_q;
				end
				default: rd_valid_s1 <= 1'b0;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire
